### sv/ipid_pkg.sv
// Package for the incremental PID controller with integral hold.
// Widths, register indexes, reset values and the gain bundle type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipid_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int VAL_W       = 16;
  localparam int ERR_W       = 18;  // setpoint - sample spans -4095..65535
  localparam int D2_W        = 19;  // e - 2*e1 + e2
  localparam int ACC_W       = 32;
  localparam int FRAC_BITS   = 12;
  localparam int SUM_W       = 37;  // exact sum of the three Q.12 products
  localparam int INC_W       = SUM_W - FRAC_BITS;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_ADDR_W  = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SETPOINT = 3'd0,
    REG_GAIN_P   = 3'd1,
    REG_GAIN_I   = 3'd2,
    REG_GAIN_D   = 3'd3,
    REG_OUT_MAX  = 3'd4,
    REG_OUT_MIN  = 3'd5,
    REG_INIT_OUT = 3'd6
  } ipid_reg_t;

  localparam logic [VAL_W-1:0] RST_SETPOINT = 16'd0;
  localparam logic [VAL_W-1:0] RST_GAIN_P   = 16'd819;
  localparam logic [VAL_W-1:0] RST_GAIN_I   = 16'd41;
  localparam logic [VAL_W-1:0] RST_GAIN_D   = 16'd246;
  localparam logic [VAL_W-1:0] RST_OUT_MAX  = 16'd500;
  localparam logic [VAL_W-1:0] RST_OUT_MIN  = 16'd20;
  localparam logic [VAL_W-1:0] RST_INIT_OUT = 16'd10;

  typedef struct packed {
    logic [VAL_W-1:0] kp;
    logic [VAL_W-1:0] ki;
    logic [VAL_W-1:0] kd;
  } ipid_gains_t;

endpackage

`default_nettype wire

### sv/ipid_incr.sv
// Velocity-form PID increment: three products, exact sum, shift toward zero.
// Depends on ipid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipid_incr (
  input  wire logic signed [ipid_pkg::ERR_W-1:0] err,
  input  wire logic signed [ipid_pkg::ERR_W-1:0] err_prev,
  input  wire logic signed [ipid_pkg::ERR_W-1:0] err_older,
  input  wire ipid_pkg::ipid_gains_t             gains,
  input  wire logic                              hold,
  output logic signed [ipid_pkg::INC_W-1:0]      incr
);
  import ipid_pkg::*;

  logic signed [ERR_W-1:0]       d1;
  logic signed [D2_W-1:0]        err_x;
  logic signed [D2_W-1:0]        prev_x;
  logic signed [D2_W-1:0]        older_x;
  logic signed [D2_W-1:0]        d2;
  logic        [VAL_W-1:0]       ki_eff;
  logic signed [VAL_W+ERR_W:0]   p_prod;
  logic signed [VAL_W+ERR_W:0]   i_prod;
  logic signed [VAL_W+D2_W:0]    d_prod;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SUM_W-1:0]       sum_adj;
  logic signed [SUM_W-1:0]       sum_sh;

  assign d1      = err - err_prev;
  assign err_x   = D2_W'(err);
  assign prev_x  = D2_W'(err_prev);
  assign older_x = D2_W'(err_older);
  assign d2      = err_x - (prev_x <<< 1) + older_x;
  assign ki_eff  = hold ? '0 : gains.ki;

  assign p_prod = $signed({1'b0, gains.kp}) * d1;
  assign i_prod = $signed({1'b0, ki_eff}) * err;
  assign d_prod = $signed({1'b0, gains.kd}) * d2;

  assign sum = SUM_W'(p_prod) + SUM_W'(i_prod) + SUM_W'(d_prod);

  // bias negatives so the arithmetic shift truncates toward zero
  assign sum_adj = sum + (sum[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : SUM_W'(0));
  assign sum_sh  = sum_adj >>> FRAC_BITS;
  assign incr    = sum_sh[INC_W-1:0];

endmodule

`default_nettype wire

### sv/incremental_pid_with_integral_hold.sv
// Incremental PID controller with integral hold, top level.
// Path: input register, then result register; error history and accumulator update in one step.
// Throughput: one item per cycle unless out_tready stalls the result register.
// Reset (rst_n low, synchronous): registers to defaults, error history zero, accumulator 10.
// Writing initial_output presets acc_r unless s1_fire. cfg_ready is always high.
// Depends on ipid_pkg and ipid_incr.
`timescale 1ns / 1ps
`default_nettype none

module incremental_pid_with_integral_hold (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [ipid_pkg::IN_TDATA_W-1:0]    in_tdata,   // [11:0] feedback_sample
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [ipid_pkg::OUT_TDATA_W-1:0]        out_tdata,  // [15:0] drive_value
  output logic                                    out_tuser,  // [0] integral_held
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ipid_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [ipid_pkg::VAL_W-1:0]         cfg_data
);
  import ipid_pkg::*;

  logic [VAL_W-1:0]        setpoint_r;
  ipid_gains_t             gains_r;
  logic [VAL_W-1:0]        out_max_r;
  logic [VAL_W-1:0]        out_min_r;
  logic [VAL_W-1:0]        init_out_r;

  logic signed [ERR_W-1:0] err_prev_r;
  logic signed [ERR_W-1:0] err_older_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  logic                    s1_v_r;
  logic [SAMPLE_W-1:0]     s1_sample_r;
  logic                    s1_fire;

  logic                    out_v_r;
  logic [VAL_W-1:0]        out_drive_r;
  logic                    out_held_r;

  logic                    cfg_fire;
  logic signed [ERR_W-1:0] err;
  logic                    err_zero;
  logic signed [ACC_W-1:0] omax_x;
  logic signed [ACC_W-1:0] omin_x;
  logic                    held;
  logic signed [INC_W-1:0] incr;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_new;
  logic [VAL_W-1:0]        drive;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  assign s1_fire   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_fire;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_held_r;

  // ---- datapath ----
  assign err = $signed({{(ERR_W-VAL_W){1'b0}}, setpoint_r})
             - $signed({{(ERR_W-SAMPLE_W){1'b0}}, s1_sample_r});
  assign err_zero = (err == '0);
  assign omax_x   = $signed({{(ACC_W-VAL_W){1'b0}}, out_max_r});
  assign omin_x   = $signed({{(ACC_W-VAL_W){1'b0}}, out_min_r});
  assign held     = ((acc_r >= omax_x) && !err[ERR_W-1])
                 || ((acc_r <= omin_x) && (err[ERR_W-1] || err_zero));

  ipid_incr u_incr (
    .err       (err),
    .err_prev  (err_prev_r),
    .err_older (err_older_r),
    .gains     (gains_r),
    .hold      (held),
    .incr      (incr)
  );

  assign acc_sum = (ACC_W+1)'(acc_r) + (ACC_W+1)'(incr);

  always_comb begin
    // saturate when the two top bits disagree
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_new = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_new = acc_sum[ACC_W-1:0];
    end
  end

  // upper limit wins when the limits cross
  always_comb begin
    if (acc_new >= omax_x) begin
      drive = out_max_r;
    end else if (acc_new <= omin_x) begin
      drive = out_min_r;
    end else begin
      drive = acc_new[VAL_W-1:0];
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (s1_fire) begin
      acc_nxt = acc_new;
    end else if (cfg_fire && cfg_addr == REG_INIT_OUT) begin
      acc_nxt = $signed({{(ACC_W-VAL_W){1'b0}}, cfg_data});
    end
  end

  // ---- control and state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r  <= RST_SETPOINT;
      gains_r     <= '{kp: RST_GAIN_P, ki: RST_GAIN_I, kd: RST_GAIN_D};
      out_max_r   <= RST_OUT_MAX;
      out_min_r   <= RST_OUT_MIN;
      init_out_r  <= RST_INIT_OUT;
      err_prev_r  <= '0;
      err_older_r <= '0;
      acc_r       <= $signed({{(ACC_W-VAL_W){1'b0}}, RST_INIT_OUT});
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_addr)
          REG_SETPOINT: setpoint_r <= cfg_data;
          REG_GAIN_P:   gains_r.kp <= cfg_data;
          REG_GAIN_I:   gains_r.ki <= cfg_data;
          REG_GAIN_D:   gains_r.kd <= cfg_data;
          REG_OUT_MAX:  out_max_r  <= cfg_data;
          REG_OUT_MIN:  out_min_r  <= cfg_data;
          REG_INIT_OUT: init_out_r <= cfg_data;
          default: ;
        endcase
      end
      acc_r <= acc_nxt;
      if (s1_fire) begin
        err_prev_r  <= err;
        err_older_r <= err_prev_r;
      end
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (s1_fire) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sample_r <= in_tdata[SAMPLE_W-1:0];
    end
    if (s1_fire) begin
      out_drive_r <= drive;
      out_held_r  <= held;
    end
  end

`ifndef SYNTH
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_v_r)
    else $error("result register not loaded after item step");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && out_v_r && !out_tready))
    else $error("input stalled without a blocked result");

  a_preset_loads_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_fire && cfg_addr == REG_INIT_OUT && !s1_fire)
      |=> (acc_r == $signed({{(ACC_W-VAL_W){1'b0}}, init_out_r})))
    else $error("accumulator preset mismatch");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
// Testbench for incremental_pid_with_integral_hold: directed and random feedback samples,
// checked against an in-bench velocity-form PID predictor with integral hold and clamping.
// Depends on ipid_pkg and the incremental_pid_with_integral_hold RTL.
`timescale 1ns / 1ps

module testbench;
  import ipid_pkg::*;

  localparam int     DRAIN   = 4;     // pipeline is two stages deep
  localparam int     LIMIT   = 2000;  // cycles without any transfer
  localparam int     HOLD_N  = 150;   // long output hold-off
  localparam longint ACC_HI  = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO  = -(longint'(1) <<< (ACC_W - 1));
  localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;  // not decoded by the block

  typedef struct packed {
    logic [VAL_W-1:0] drive;
    logic             held;
  } pid_step_t;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
  logic [VAL_W-1:0]       cfg_data  = '0;

  // predictor state
  longint sp_reg, kp_reg, ki_reg, kd_reg, max_reg, min_reg, init_reg;
  longint err_prev, err_older, acc_out;

  pid_step_t drive_queue[$];
  int  errors    = 0;
  int  n_samples = 0;
  int  n_checked = 0;
  int  n_held    = 0;
  int  n_writes  = 0;
  int  idle_cycles = 0;
  int  hold_left   = 0;
  int  stall_left  = 0;
  bit  hold_req    = 1'b0;
  bit  rx_quiet    = 1'b0;
  bit  tx_quiet    = 1'b0;

  incremental_pid_with_integral_hold dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void pid_reset();
    sp_reg    = RST_SETPOINT;
    kp_reg    = RST_GAIN_P;
    ki_reg    = RST_GAIN_I;
    kd_reg    = RST_GAIN_D;
    max_reg   = RST_OUT_MAX;
    min_reg   = RST_OUT_MIN;
    init_reg  = RST_INIT_OUT;
    err_prev  = 0;
    err_older = 0;
    acc_out   = init_reg;
  endfunction

  function automatic void pid_write(logic [CFG_ADDR_W-1:0] addr, logic [VAL_W-1:0] data);
    case (addr)
      REG_SETPOINT: sp_reg  = data;
      REG_GAIN_P:   kp_reg  = data;
      REG_GAIN_I:   ki_reg  = data;
      REG_GAIN_D:   kd_reg  = data;
      REG_OUT_MAX:  max_reg = data;
      REG_OUT_MIN:  min_reg = data;
      REG_INIT_OUT: begin
        init_reg = data;
        acc_out  = data;  // preset, error history untouched
      end
      default: ;
    endcase
  endfunction

  function automatic pid_step_t pid_predict(logic [SAMPLE_W-1:0] sample);
    longint    err, ki_eff, sum, inc, nxt, drv;
    pid_step_t r;
    err    = sp_reg - longint'(sample);
    r.held = (acc_out >= max_reg && err >= 0) || (acc_out <= min_reg && err <= 0);
    ki_eff = r.held ? 0 : ki_reg;
    sum    = kp_reg * (err - err_prev) + ki_eff * err
           + kd_reg * (err - 2 * err_prev + err_older);
    inc    = (sum < 0) ? -((-sum) >>> FRAC_BITS) : (sum >>> FRAC_BITS);
    nxt    = acc_out + inc;
    if (nxt > ACC_HI) nxt = ACC_HI;
    if (nxt < ACC_LO) nxt = ACC_LO;
    err_older = err_prev;
    err_prev  = err;
    acc_out   = nxt;
    // upper clamp wins when the limits are inverted
    if (nxt >= max_reg) drv = max_reg;
    else if (nxt <= min_reg) drv = min_reg;
    else drv = nxt;
    r.drive = VAL_W'(drv);
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    else if (r < 96) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic int tx_gap();
    if (tx_quiet) return 0;
    return ($urandom_range(0, 99) < 55) ? 0 : idle_len();
  endfunction

  // one sample transfer; valid stays high when gap is zero
  task automatic push_sample(input logic [SAMPLE_W-1:0] sample, input int gap);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(sample);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    drive_queue.push_back(pid_predict(sample));
    n_samples++;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (drive_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [VAL_W-1:0] data);
    drain_results();
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pid_write(addr, data);
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    push_sample(12'd0, 1);
    push_sample(12'hFFF, 0);
    push_sample(12'd2048, 2);
    push_sample(12'd0, 1);
  endtask

  // largest gains and errors; accumulator swings far negative
  task automatic test_saturating_extremes();
    write_reg(REG_SETPOINT, 16'hFFFF);
    write_reg(REG_GAIN_P, 16'hFFFF);
    write_reg(REG_GAIN_I, 16'hFFFF);
    write_reg(REG_GAIN_D, 16'hFFFF);
    write_reg(REG_OUT_MAX, 16'hFFFF);
    write_reg(REG_OUT_MIN, 16'h0000);
    write_reg(REG_INIT_OUT, 16'h0000);
    push_sample(12'd0, 0);
    push_sample(12'hFFF, 0);
    push_sample(12'd0, 0);
    push_sample(12'hFFF, 1);
    write_reg(REG_SETPOINT, 16'h0000);
    push_sample(12'hFFF, 0);
    push_sample(12'hFFF, 0);
    push_sample(12'd0, 1);
    write_reg(REG_GAIN_P, 16'h0000);
    write_reg(REG_GAIN_I, 16'h0000);
    write_reg(REG_GAIN_D, 16'h0000);
    push_sample(12'hABC, 1);
  endtask

  task automatic test_inverted_limits();
    write_reg(REG_GAIN_P, RST_GAIN_P);
    write_reg(REG_GAIN_I, RST_GAIN_I);
    write_reg(REG_GAIN_D, RST_GAIN_D);
    write_reg(REG_OUT_MAX, 16'd100);
    write_reg(REG_OUT_MIN, 16'd300);
    write_reg(REG_INIT_OUT, 16'd200);
    push_sample(12'd0, 0);
    push_sample(12'hFFF, 0);
    push_sample(12'd0, 1);
  endtask

  // accumulator exactly on a limit, error zero and one count either side
  task automatic test_hold_boundaries();
    write_reg(REG_SETPOINT, 16'd1000);
    write_reg(REG_OUT_MAX, 16'd300);
    write_reg(REG_OUT_MIN, 16'd100);
    write_reg(REG_INIT_OUT, 16'd300);
    push_sample(12'd1000, 1);
    write_reg(REG_INIT_OUT, 16'd100);
    push_sample(12'd1000, 1);
    write_reg(REG_INIT_OUT, 16'd300);
    push_sample(12'd1001, 1);
    write_reg(REG_INIT_OUT, 16'd100);
    push_sample(12'd999, 1);
  endtask

  task automatic test_output_preset();
    write_reg(REG_OUT_MAX, 16'hFFFF);
    write_reg(REG_OUT_MIN, 16'h0000);
    push_sample(12'd200, 1);
    write_reg(REG_INIT_OUT, 16'd40000);
    push_sample(12'd1500, 0);
    push_sample(12'd700, 1);
  endtask

  task automatic test_ignored_index();
    write_reg(REG_NONE, 16'hFFFF);
    push_sample(12'd1000, 0);
    push_sample(12'd1200, 1);
  endtask

  // receiver holds off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    int k;
    hold_req = 1'b1;
    for (k = 0; k < 40; k++) push_sample(SAMPLE_W'($urandom_range(0, 4095)), (k == 39) ? 1 : 0);
    drain_results();
  endtask

  task automatic test_sender_pause();
    int k, round;
    for (round = 0; round < 3; round++) begin
      for (k = 0; k < 8; k++) push_sample(SAMPLE_W'($urandom_range(0, 4095)), (k == 7) ? 1 : tx_gap());
      drain_results();
    end
  endtask

  task automatic randomize_settings();
    int r, lo, hi, k;
    r = $urandom_range(0, 99);
    if (r < 15) write_reg(REG_SETPOINT, ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000);
    else if (r < 80) write_reg(REG_SETPOINT, VAL_W'($urandom_range(0, 4095)));
    else write_reg(REG_SETPOINT, VAL_W'($urandom_range(0, 65535)));
    for (k = 0; k < 3; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10) hi = 0;
      else if (r < 20) hi = 65535;
      else if (r < 70) hi = $urandom_range(0, 2000);
      else hi = $urandom_range(0, 65535);
      case (k)
        0: write_reg(REG_GAIN_P, VAL_W'(hi));
        1: write_reg(REG_GAIN_I, VAL_W'(hi));
        default: write_reg(REG_GAIN_D, VAL_W'(hi));
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      lo = $urandom_range(0, 3000);
      hi = lo + $urandom_range(0, 3000);
    end else if (r < 85) begin
      lo = 0;
      hi = 65535;
    end else begin
      lo = $urandom_range(0, 65535);
      hi = $urandom_range(0, 65535);
    end
    write_reg(REG_OUT_MAX, VAL_W'(hi));
    write_reg(REG_OUT_MIN, VAL_W'(lo));
    if ($urandom_range(0, 3) == 0) write_reg(REG_INIT_OUT, VAL_W'($urandom_range(0, 65535)));
    else write_reg(REG_INIT_OUT, VAL_W'((lo + hi) / 2));
  endtask

  task automatic test_random_loops();
    int phase, k, r, sample, target;
    sample = 0;
    for (phase = 0; phase < 10; phase++) begin
      randomize_settings();
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      for (k = 0; k < 120; k++) begin
        r = $urandom_range(0, 99);
        target = (sp_reg > 4095) ? 4095 : int'(sp_reg);
        if (r < 45) sample = target + int'($urandom_range(0, 64)) - 32;
        else if (r < 80) sample = sample + int'($urandom_range(0, 16)) - 8;
        else sample = $urandom_range(0, 4095);
        if (sample < 0) sample = 0;
        if (sample > 4095) sample = 4095;
        push_sample(SAMPLE_W'(sample), (k == 119) ? 1 : tx_gap());
        if ($urandom_range(0, 99) == 0) drain_results();
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // receiver: random stalls, quiet stretches, and the requested long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_N;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (!rx_quiet && $urandom_range(0, 99) < 25) stall_left = idle_len();
    end
  end

  always @(posedge clk) begin
    pid_step_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (drive_queue.size() == 0) begin
        $error("result transfer with no sample pending: drive_value %0d", out_tdata);
        errors++;
      end else begin
        want = drive_queue.pop_front();
        n_checked++;
        if (want.held) n_held++;
        if (out_tdata != want.drive) begin
          $error("drive_value: expected %0d, got %0d", want.drive, out_tdata);
          errors++;
        end
        if (out_tuser != want.held) begin
          $error("integral_held: expected %0d, got %0d", want.held, out_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= LIMIT) begin
        $display("timeout: %0d cycles without a transfer", LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    pid_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_saturating_extremes();
    test_inverted_limits();
    test_hold_boundaries();
    test_output_preset();
    test_ignored_index();
    test_backpressure();
    test_sender_pause();
    test_random_loops();
    drain_results();
    repeat (DRAIN * 4) @(posedge clk);
    if (drive_queue.size() != 0) begin
      $error("%0d expected results never arrived", drive_queue.size());
      errors++;
    end
    $display("Checked %0d of %0d controller steps, %0d with integral hold, across %0d writes;",
             n_checked, n_samples, n_held, n_writes);
    $display("covered extreme gains, inverted limits, presets, stalls and sender pauses.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/ipid_pkg.sv
sv/ipid_incr.sv
sv/incremental_pid_with_integral_hold.sv
tb/testbench.sv
